// ===== rtl/grisu_digit_generator_assert.svh =====
// Assertion helpers for the digit generator RTL.
`ifndef GRISU_DIGIT_GENERATOR_ASSERT_SVH
`define GRISU_DIGIT_GENERATOR_ASSERT_SVH

// Same-cycle implication or invariant.
`define GDG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent this cycle, consequent on the next edge.
`define GDG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/gdg_pkg.sv =====
`timescale 1ns / 1ps

package gdg_pkg;

   localparam int MAX_DIGITS = 64;

   typedef logic [63:0]        frac_type;
   typedef logic signed [6:0]  bexp_type;
   typedef logic signed [9:0]  dexp_type;
   typedef logic [3:0]         digit_type;
   typedef logic [6:0]         count_type;
   typedef logic signed [7:0]  kappa_type;
   typedef logic [5:0]         shift_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INT_DIG,
      ST_INT_CHK,
      ST_FRAC_MUL,
      ST_FRAC_DIG,
      ST_FINISH
   } state_type;

   localparam bexp_type EXP_MIN = -7'sd60;
   localparam bexp_type EXP_MAX = -7'sd32;
   localparam dexp_type K_MIN   = -10'sd512;
   localparam dexp_type K_MAX   = 10'sd511;

   localparam logic [31:0] POW10 [10] = '{
      32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
      32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
   };

   // Quotient digit of p1 / 10^idx, by compare against the nine multiples.
   function automatic digit_type quot_digit(logic [31:0] p1, logic [3:0] idx);
      logic [33:0] div;
      digit_type   q;
      div = {2'b00, POW10[idx]};
      q   = '0;
      for (int j = 1; j <= 9; j++) begin
         if ({2'b00, p1} >= 34'(34'(j) * div)) begin
            q = 4'(j);
         end
      end
      return q;
   endfunction

endpackage

// ===== rtl/gdg_ifs.sv =====
`timescale 1ns / 1ps

interface gdg_req_if;
   import gdg_pkg::*;
   logic     valid;
   logic     ready;
   frac_type mp_frac;
   bexp_type mp_exp;
   frac_type delta_frac;
   dexp_type k_in;

   modport source (output valid, mp_frac, mp_exp, delta_frac, k_in, input ready);
   modport sink   (input valid, mp_frac, mp_exp, delta_frac, k_in, output ready);
endinterface

interface gdg_rsp_if;
   import gdg_pkg::*;
   logic      valid;
   logic      ready;
   digit_type digit;
   logic      digit_valid;
   logic      last;
   dexp_type  k_out;
   count_type digit_count;
   logic      truncated;

   modport source (output valid, digit, digit_valid, last, k_out, digit_count, truncated,
                   input ready);
   modport sink   (input valid, digit, digit_valid, last, k_out, digit_count, truncated,
                   output ready);
endinterface

// ===== rtl/grisu_digit_generator.sv =====
`timescale 1ns / 1ps
// Sequence: an accept in IDLE, then INT_DIG and INT_CHK for each integral position tried
//   (up to 10), then FRAC_MUL and FRAC_DIG for each fraction step (leading-zero steps
//   included), then FINISH.
// Throughput: one item at a time; req_ch.ready is high only while idle. The shared
//   digit unit (quotient compare / times-ten adder) produces each digit.
// Reset: synchronous, active high; clears the sequencer, the digit count, the pending
//   digit and the output register. Results stall the sequencer when the output register
//   is full.
`include "grisu_digit_generator_assert.svh"

module grisu_digit_generator (
   input logic        clock,
   input logic        reset,
   gdg_req_if.sink    req_ch,
   gdg_rsp_if.source  rsp_ch
);
   import gdg_pkg::*;

   // Sequencer and working registers
   state_type state_ff, state_in;
   logic [31:0] p1_ff, p1_in;          // integral remainder
   frac_type  p2_ff, p2_in;            // fractional part (times ten in FRAC_MUL)
   frac_type  dlt_ff, dlt_in;          // delta, wraps when scaled
   shift_type s_ff, s_in;              // fraction width, 32..60
   kappa_type kappa_ff, kappa_in;      // remaining digit position
   dexp_type  kexp_ff, kexp_in;
   count_type len_ff, len_in;
   logic      trunc_ff, trunc_in;

   // One digit is held back so the final one can carry last.
   digit_type pend_ff, pend_in;
   logic      pend_valid_ff, pend_valid_in;

   // Output register
   logic      out_valid_ff, out_valid_in;
   digit_type out_digit_ff, out_digit_in;
   logic      out_dvalid_ff, out_dvalid_in;
   logic      out_last_ff, out_last_in;
   dexp_type  out_k_ff, out_k_in;
   count_type out_count_ff, out_count_in;
   logic      out_trunc_ff, out_trunc_in;

   // Request decode: saturate exponent, split boundary
   bexp_type        acc_e;
   logic signed [6:0] neg_e;
   shift_type       acc_s;
   frac_type        acc_sh;
   frac_type        acc_mask;

   assign acc_e = (req_ch.mp_exp < EXP_MIN) ? EXP_MIN :
                  (req_ch.mp_exp > EXP_MAX) ? EXP_MAX : req_ch.mp_exp;
   assign neg_e    = -acc_e;
   assign acc_s    = neg_e[5:0];
   assign acc_sh   = req_ch.mp_frac >> acc_s;
   assign acc_mask = (64'd1 << acc_s) - 64'd1;

   // Shared digit unit
   kappa_type   km1;
   logic [3:0]  idx;
   digit_type   int_d;
   logic [35:0] int_prod;
   frac_type    rest;
   frac_type    mask;
   frac_type    frac_sh;
   digit_type   frac_d;
   frac_type    p2_masked;
   digit_type   cur_d;
   logic        emit;
   logic        len_full;
   logic        out_free;
   logic signed [10:0] ksum;
   dexp_type    k_sat;

   assign km1      = kappa_ff - 8'sd1;
   assign idx      = km1[3:0];
   assign int_d    = quot_digit(p1_ff, idx);
   assign int_prod = {4'b0000, POW10[idx]} * {32'd0, int_d};
   assign rest     = ({32'd0, p1_ff} << s_ff) | p2_ff;
   assign mask     = (64'd1 << s_ff) - 64'd1;
   assign frac_sh  = p2_ff >> s_ff;
   assign frac_d   = frac_sh[3:0];
   assign p2_masked = p2_ff & mask;
   assign cur_d    = (state_ff == ST_FRAC_DIG) ? frac_d : int_d;
   assign emit     = (cur_d != 4'd0) || (len_ff != 7'd0);
   assign len_full = (len_ff >= 7'(MAX_DIGITS));
   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign ksum     = 11'(kexp_ff) + 11'(kappa_ff);
   assign k_sat    = (ksum < 11'(K_MIN)) ? K_MIN :
                     (ksum > 11'(K_MAX)) ? K_MAX : ksum[9:0];

   always_comb begin
      state_in      = state_ff;
      p1_in         = p1_ff;
      p2_in         = p2_ff;
      dlt_in        = dlt_ff;
      s_in          = s_ff;
      kappa_in      = kappa_ff;
      kexp_in       = kexp_ff;
      len_in        = len_ff;
      trunc_in      = trunc_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_digit_in  = out_digit_ff;
      out_dvalid_in = out_dvalid_ff;
      out_last_in   = out_last_ff;
      out_k_in      = out_k_ff;
      out_count_in  = out_count_ff;
      out_trunc_in  = out_trunc_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               p1_in         = acc_sh[31:0];
               p2_in         = req_ch.mp_frac & acc_mask;
               dlt_in        = req_ch.delta_frac;
               s_in          = acc_s;
               kappa_in      = 8'sd10;
               kexp_in       = req_ch.k_in;
               len_in        = '0;
               trunc_in      = 1'b0;
               pend_valid_in = 1'b0;
               state_in      = ST_INT_DIG;
            end
         end
         ST_INT_DIG, ST_FRAC_DIG: begin
            if (emit && len_full) begin
               // limit reached: stop before this digit
               trunc_in = 1'b1;
               state_in = ST_FINISH;
            end else if (!(emit && pend_valid_ff && !out_free)) begin
               if (emit) begin
                  if (pend_valid_ff) begin
                     out_valid_in  = 1'b1;
                     out_digit_in  = pend_ff;
                     out_dvalid_in = 1'b1;
                     out_last_in   = 1'b0;
                     out_k_in      = '0;
                     out_count_in  = '0;
                     out_trunc_in  = 1'b0;
                  end
                  pend_in       = cur_d;
                  pend_valid_in = 1'b1;
                  len_in        = len_ff + 7'd1;
               end
               kappa_in = km1;
               if (state_ff == ST_INT_DIG) begin
                  p1_in    = p1_ff - int_prod[31:0];
                  state_in = ST_INT_CHK;
               end else begin
                  p2_in    = p2_masked;
                  state_in = (p2_masked > dlt_ff) ? ST_FRAC_MUL : ST_FINISH;
               end
            end
         end
         ST_INT_CHK: begin
            if (rest <= dlt_ff) begin
               state_in = ST_FINISH;
            end else if (kappa_ff > 8'sd0) begin
               state_in = ST_INT_DIG;
            end else begin
               state_in = ST_FRAC_MUL;
            end
         end
         ST_FRAC_MUL: begin
            // p2 < 2^60, so times ten stays in 64 bits; delta wraps
            p2_in    = (p2_ff << 3) + (p2_ff << 1);
            dlt_in   = (dlt_ff << 3) + (dlt_ff << 1);
            state_in = ST_FRAC_DIG;
         end
         ST_FINISH: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_digit_in  = pend_valid_ff ? pend_ff : 4'd0;
               out_dvalid_in = pend_valid_ff;
               out_last_in   = 1'b1;
               out_k_in      = k_sat;
               out_count_in  = len_ff;
               out_trunc_in  = trunc_ff;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         len_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff         <= p1_in;
      p2_ff         <= p2_in;
      dlt_ff        <= dlt_in;
      s_ff          <= s_in;
      kappa_ff      <= kappa_in;
      kexp_ff       <= kexp_in;
      trunc_ff      <= trunc_in;
      pend_ff       <= pend_in;
      out_digit_ff  <= out_digit_in;
      out_dvalid_ff <= out_dvalid_in;
      out_last_ff   <= out_last_in;
      out_k_ff      <= out_k_in;
      out_count_ff  <= out_count_in;
      out_trunc_ff  <= out_trunc_in;
   end

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.digit       = out_digit_ff;
   assign rsp_ch.digit_valid = out_dvalid_ff;
   assign rsp_ch.last        = out_last_ff;
   assign rsp_ch.k_out       = out_k_ff;
   assign rsp_ch.digit_count = out_count_ff;
   assign rsp_ch.truncated   = out_trunc_ff;

   `GDG_ASSERT(a_len_cap, clock, reset, len_ff <= 7'(MAX_DIGITS), "digit count above limit")
   `GDG_ASSERT(a_pend_len, clock, reset, (state_ff != ST_IDLE) |-> (pend_valid_ff == (len_ff != 7'd0)), "pending digit out of step with count")
   `GDG_ASSERT(a_mid_digit, clock, reset, (out_valid_ff && !out_last_ff) |-> out_dvalid_ff, "non-last item without digit")
   `GDG_ASSERT_NEXT(a_start, clock, reset, (state_ff == ST_IDLE) && req_ch.valid, state_ff == ST_INT_DIG, "accepted item did not start")

endmodule
